FILE: rtl/four_channel_dma_sound_engine_defines.svh
// ------------------------------------------------------------------
// four_channel_dma_sound_engine_defines
// Assertion helpers for the sound engine.
// ------------------------------------------------------------------
`ifndef FOUR_CHANNEL_DMA_SOUND_ENGINE_DEFINES_SVH
`define FOUR_CHANNEL_DMA_SOUND_ENGINE_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define FCD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define FCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/fcd_pkg.sv
// ------------------------------------------------------------------
// fcd_pkg
// Shared types and constants of the four-channel sound engine.
// ------------------------------------------------------------------
package fcd_pkg;

    localparam int RAM_BYTES      = 524288;
    localparam int RAM_AW         = $clog2(RAM_BYTES);
    localparam logic [3:0] ENABLE_DELAY   = 4'd4;
    localparam logic [2:0] TEMPO_PRESCALE = 3'd5;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [3:0] R_AIDX    = 4'd0;
    localparam logic [3:0] R_ADATA   = 4'd1;
    localparam logic [3:0] R_ADMACON = 4'd2;
    localparam logic [3:0] R_AINTENA = 4'd3;
    localparam logic [3:0] R_AINTREQ = 4'd4;
    localparam logic [3:0] R_ACTRL   = 4'd5;
    localparam logic [3:0] R_SPTR2   = 4'd6;
    localparam logic [3:0] R_SPTR1   = 4'd7;
    localparam logic [3:0] R_SPTR0   = 4'd8;
    localparam logic [3:0] R_SDATA   = 4'd9;
    localparam logic [3:0] R_ASTAT   = 4'd10;
    localparam logic [3:0] R_TIMER1  = 4'd11;
    localparam logic [3:0] R_TIMER0  = 4'd12;

    // controller to datapath
    typedef struct packed {
        logic       start;     // do bus access or tick prologue
        logic       slot;      // run one channel fetch slot
        logic [1:0] ch;        // channel of the slot
        logic       finish;    // tempo timer and output register
    } fcd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
    } fcd_stat_t;

endpackage

FILE: rtl/fcd_ctrl.sv
// ------------------------------------------------------------------
// fcd_ctrl
// Sequencer: accept, four channel slots on a tick, finish, deliver.
// ------------------------------------------------------------------
module fcd_ctrl
    import fcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_fire,
    input  logic      out_fire,
    input  fcd_stat_t stat,
    output fcd_cmd_t  cmd,
    output logic      in_ready,
    output logic      out_valid
);
    typedef enum logic [2:0] {S_IDLE, S_START, S_SLOT, S_FIN, S_OUT} state_t;

    state_t     state_reg, state_next;
    logic [1:0] ch_reg, ch_next;

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        cmd        = '0;
        cmd.ch     = ch_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_START;
            end
            S_START:
            begin
                cmd.start  = 1'b1;
                ch_next    = 2'd0;
                state_next = S_SLOT;
            end
            S_SLOT:
            begin
                cmd.slot = stat.is_tick;
                ch_next  = ch_reg + 2'd1;
                if (ch_reg == 2'd3 || !stat.is_tick)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_fire)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg    <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

endmodule

FILE: rtl/fcd_datapath.sv
// ------------------------------------------------------------------
// fcd_datapath
// Register file, channel state, sample RAM, tempo timer and mixer.
// ------------------------------------------------------------------
module fcd_datapath
    import fcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_fire,
    input  logic [1:0]   operation,
    input  logic [3:0]   register_address,
    input  logic [7:0]   write_data,
    input  fcd_cmd_t     cmd,
    output fcd_stat_t    stat,
    output logic [7:0]   read_data,
    output logic         interrupt_line,
    output logic signed [16:0] left_mix,
    output logic signed [16:0] right_mix,
    output logic [15:0]  bad_fetch_count
);
    logic [7:0]  sample_ram [RAM_BYTES];
    // per channel: state bytes 0..10, byte k at [8k+7:8k]; bytes 11..15 are live
    logic [87:0] sf_reg [4];
    logic [5:0]  sidx_reg;
    logic [18:0] lstart_reg [4];
    logic [15:0] llen_reg [4];
    logic [15:0] per_reg [4];
    logic [6:0]  vol_reg [4];
    logic [1:0]  att_reg [4];
    logic [7:0]  held_reg [4];
    logic [18:0] fptr_reg [4];
    logic [17:0] left_reg [4];
    logic [15:0] nft_reg [4];
    logic [3:0]  dma_reg;
    logic [3:0]  cd_reg [4];
    logic [5:0]  ien_reg, ireq_reg;
    logic [7:0]  ctrl_reg;
    logic [18:0] rptr_reg;
    logic [15:0] tper_reg, tcnt_reg, tmatch_reg;
    logic [2:0]  pre_reg;
    logic [15:0] clk_reg;
    logic [15:0] bad_reg;
    logic [1:0]  op_reg;
    logic [3:0]  ra_reg;
    logic [7:0]  wd_reg;
    logic [7:0]  rd_reg;
    logic [7:0]  ram_q;

    function automatic logic [17:0] blen(input logic [15:0] w);
        blen = (w == 16'd0) ? 18'd131072 : {1'b0, w, 1'b0};
    endfunction

    function automatic logic signed [16:0] chout(input logic [7:0] s, input logic [6:0] v);
        logic [7:0] code;
        code = (v > 7'd64) ? 8'd255 : ((v == 7'd64) ? 8'd255 : {v[5:0], 2'b00});
        chout = 17'(($signed({1'b0, s}) - 10'sd128) * $signed({1'b0, code}));
    endfunction

    logic in_range_r, in_range_f;
    logic [18:0] fp;
    assign fp         = fptr_reg[cmd.ch];
    assign in_range_r = ({13'd0, rptr_reg} < 32'(RAM_BYTES));
    assign in_range_f = ({13'd0, fp} < 32'(RAM_BYTES));

    // one RAM port: bus read on accept, write on start, channel fetches on start and slots
    always_ff @(posedge clk)
    begin
        if (in_fire)
            ram_q <= sample_ram[RAM_AW'(rptr_reg)];
        else if (cmd.start && op_reg == OP_TICK)
            ram_q <= sample_ram[RAM_AW'(fptr_reg[0])];
        else if (cmd.slot)
            ram_q <= sample_ram[RAM_AW'(fptr_reg[cmd.ch + 2'd1])];
        if (cmd.start && op_reg == OP_WRITE && ra_reg == R_SDATA && in_range_r)
            sample_ram[RAM_AW'(rptr_reg)] <= wd_reg;
    end

    assign stat.is_tick = (op_reg == OP_TICK);

    logic [15:0] clk_inc;
    assign clk_inc = clk_reg + 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 4; c++)
            begin
                sf_reg[c] <= '0;
                lstart_reg[c] <= '0; llen_reg[c] <= '0; per_reg[c] <= '0;
                vol_reg[c] <= '0; att_reg[c] <= '0; held_reg[c] <= 8'h80;
                fptr_reg[c] <= '0; left_reg[c] <= '0; nft_reg[c] <= '0;
                cd_reg[c] <= '0;
            end
            sidx_reg <= '0; dma_reg <= '0; ien_reg <= '0; ireq_reg <= '0;
            ctrl_reg <= '0; rptr_reg <= '0; tper_reg <= '0; tcnt_reg <= '0;
            tmatch_reg <= '0; pre_reg <= '0; clk_reg <= '0; bad_reg <= '0;
            op_reg <= '0; ra_reg <= '0; wd_reg <= '0; rd_reg <= '0;
            read_data <= '0; interrupt_line <= 1'b0;
            left_mix <= '0; right_mix <= '0; bad_fetch_count <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                op_reg <= operation; ra_reg <= register_address; wd_reg <= write_data;
            end
            if (cmd.start)
            begin
                if (op_reg != OP_READ)
                    rd_reg <= 8'd0;
                if (op_reg == OP_WRITE)
                begin
                    unique case (ra_reg)
                        R_AIDX: sidx_reg <= wd_reg[5:0];
                        R_ADATA:
                        begin
                            if (sidx_reg[3:0] <= 4'd10)
                            begin
                                logic [1:0]  c;
                                logic [87:0] s;
                                c = sidx_reg[5:4];
                                s = sf_reg[c];
                                s[{sidx_reg[3:0], 3'b000} +: 8] = wd_reg;
                                sf_reg[c] <= s;
                                if (sidx_reg[3:0] == 4'd9)
                                    held_reg[c] <= wd_reg;
                                else
                                begin
                                    lstart_reg[c] <= {s[2:0], s[15:8], s[23:16]};
                                    llen_reg[c]   <= {s[31:24], s[39:32]};
                                    per_reg[c]    <= {s[47:40], s[55:48]};
                                    vol_reg[c]    <= s[62:56];
                                    att_reg[c]    <= s[65:64];
                                end
                            end
                            sidx_reg <= sidx_reg + 6'd1;
                        end
                        R_ADMACON:
                            for (int c = 0; c < 4; c++)
                                if (wd_reg[c])
                                begin
                                    if (wd_reg[7])
                                    begin
                                        if (!dma_reg[c]) cd_reg[c] <= ENABLE_DELAY;
                                        dma_reg[c] <= 1'b1;
                                    end
                                    else
                                    begin
                                        dma_reg[c] <= 1'b0;
                                        cd_reg[c]  <= 4'd0;
                                    end
                                end
                        R_AINTENA:
                            ien_reg <= wd_reg[7] ? (ien_reg | wd_reg[5:0])
                                                 : (ien_reg & ~wd_reg[5:0]);
                        R_AINTREQ:
                            ireq_reg <= wd_reg[7] ? (ireq_reg | wd_reg[5:0])
                                                  : (ireq_reg & ~wd_reg[5:0]);
                        R_ACTRL:  ctrl_reg <= wd_reg;
                        R_SPTR2:  rptr_reg[18:16] <= wd_reg[2:0];
                        R_SPTR1:  rptr_reg[15:8]  <= wd_reg;
                        R_SPTR0:  rptr_reg[7:0]   <= wd_reg;
                        R_SDATA:  rptr_reg <= rptr_reg + 19'd1;
                        R_TIMER1: tper_reg[15:8] <= wd_reg;
                        R_TIMER0:
                        begin
                            tper_reg[7:0] <= wd_reg;
                            tmatch_reg <= tcnt_reg + {tper_reg[15:8], wd_reg};
                        end
                        default: ;
                    endcase
                end
                else if (op_reg == OP_READ)
                begin
                    unique case (ra_reg)
                        R_ADATA:
                        begin
                            logic [1:0]  c;
                            logic [16:0] wds;
                            logic [7:0]  v;
                            logic [87:0] s;
                            c = sidx_reg[5:4];
                            s = sf_reg[c];
                            wds = 17'((left_reg[c] + 18'd1) >> 1);
                            // live pointer and words left are read straight from the channel
                            unique case (sidx_reg[3:0])
                                4'd11: v = {5'd0, fptr_reg[c][18:16]};
                                4'd12: v = fptr_reg[c][15:8];
                                4'd13: v = fptr_reg[c][7:0];
                                4'd14: v = wds[15:8];
                                4'd15: v = wds[7:0];
                                default: v = s[{sidx_reg[3:0], 3'b000} +: 8];
                            endcase
                            rd_reg <= v;
                            sidx_reg <= sidx_reg + 6'd1;
                        end
                        R_AINTREQ: rd_reg <= {2'b00, ireq_reg};
                        R_ASTAT:   rd_reg <= {3'd0, (tper_reg != 16'd0), dma_reg};
                        R_SDATA:
                        begin
                            rd_reg   <= in_range_r ? ram_q : 8'd0;
                            rptr_reg <= rptr_reg + 19'd1;
                        end
                        default: rd_reg <= 8'd0;
                    endcase
                end
                else if (op_reg == OP_TICK)
                begin
                    clk_reg <= clk_inc;
                    for (int c = 0; c < 4; c++)
                        if (cd_reg[c] != 4'd0)
                        begin
                            cd_reg[c] <= cd_reg[c] - 4'd1;
                            if (cd_reg[c] == 4'd1)
                            begin
                                fptr_reg[c] <= lstart_reg[c];
                                left_reg[c] <= blen(llen_reg[c]);
                                nft_reg[c]  <= clk_inc + per_reg[c];
                            end
                        end
                end
            end
            // channel slot; RAM data for this channel arrived this cycle
            if (cmd.slot)
            begin
                logic [1:0]  c, t;
                logic [7:0]  byt, v;
                logic [17:0] nl;
                logic [15:0] np;
                c = cmd.ch;
                t = c + 2'd1;
                if (dma_reg[c] && cd_reg[c] == 4'd0 && per_reg[c] != 16'd0
                    && nft_reg[c] == clk_reg)
                begin
                    byt = in_range_f ? ram_q : 8'h80;
                    if (!in_range_f && bad_reg != 16'hFFFF) bad_reg <= bad_reg + 16'd1;
                    np = per_reg[c];
                    if (att_reg[c] != 2'd0)
                    begin
                        v = byt ^ 8'h80;
                        if (att_reg[c][0])
                        begin
                            per_reg[t][7:0] <= v;
                            if (t == c) np = {per_reg[c][15:8], v};
                        end
                        if (att_reg[c][1]) vol_reg[t] <= v[6:0];
                        held_reg[c] <= 8'h80;
                    end
                    else
                        held_reg[c] <= byt;
                    nl = left_reg[c] - 18'd1;
                    if (nl == 18'd0)
                    begin
                        fptr_reg[c] <= lstart_reg[c];
                        left_reg[c] <= blen(llen_reg[c]);
                        ireq_reg[c] <= 1'b1;
                    end
                    else
                    begin
                        fptr_reg[c] <= fp + 19'd1;
                        left_reg[c] <= nl;
                    end
                    nft_reg[c] <= nft_reg[c] + np;
                end
            end
            if (cmd.finish)
            begin
                logic [5:0] irq;
                irq = ireq_reg;
                if (op_reg == OP_TICK && ctrl_reg[6])
                begin
                    if (pre_reg + 3'd1 >= TEMPO_PRESCALE)
                    begin
                        pre_reg  <= 3'd0;
                        tcnt_reg <= tcnt_reg + 16'd1;
                        if (tcnt_reg + 16'd1 == tmatch_reg)
                        begin
                            irq[4] = 1'b1;
                            ireq_reg[4] <= 1'b1;
                            tmatch_reg <= tmatch_reg + tper_reg;
                        end
                    end
                    else
                        pre_reg <= pre_reg + 3'd1;
                end
                read_data       <= rd_reg;
                interrupt_line  <= (irq & ien_reg) != 6'd0;
                bad_fetch_count <= bad_reg;
                if (ctrl_reg[0])
                begin
                    left_mix  <= chout(held_reg[0], vol_reg[0]) + chout(held_reg[3], vol_reg[3]);
                    right_mix <= chout(held_reg[1], vol_reg[1]) + chout(held_reg[2], vol_reg[2]);
                end
                else
                begin
                    left_mix  <= '0;
                    right_mix <= '0;
                end
            end
        end
    end

endmodule

FILE: rtl/four_channel_dma_sound_engine.sv
// A bus item passes through the start, slot, finish and output states; a tick holds the
// slot state for each of the four channels in turn. One item at a time: the next is taken
// the cycle after the result has gone.
// A tick visits the four channels in turn through the single sample-RAM port.
// Reset (rst_n low, asynchronous) clears all control and channel state;
// the sample RAM is not cleared and reads of unwritten bytes are undefined.
// ------------------------------------------------------------------
// four_channel_dma_sound_engine
// Top level: stream ports, sequencer and datapath.
// ------------------------------------------------------------------
`include "four_channel_dma_sound_engine_defines.svh"
module four_channel_dma_sound_engine
    import fcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [1:0] operation, [5:2] register_address, [13:6] write_data
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata   // [7:0] read_data, [8] interrupt_line, [25:9] left_mix,
                                  // [42:26] right_mix, [58:43] bad_fetch_count
);
    fcd_cmd_t  cmd;
    fcd_stat_t stat;
    logic in_fire, out_fire;
    logic [7:0]  rd;
    logic        irq;
    logic signed [16:0] lm, rm;
    logic [15:0] bad;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    fcd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
        .stat(stat), .cmd(cmd), .in_ready(s_tready), .out_valid(m_tvalid)
    );

    fcd_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
        .operation(s_tdata[1:0]), .register_address(s_tdata[5:2]),
        .write_data(s_tdata[13:6]), .cmd(cmd), .stat(stat),
        .read_data(rd), .interrupt_line(irq), .left_mix(lm), .right_mix(rm),
        .bad_fetch_count(bad)
    );

    assign m_tdata = {5'd0, bad, rm, lm, irq, rd};

    `FCD_ASSERT_IMP(a_no_both, s_tready, !m_tvalid)
    `FCD_ASSERT_NEXT(a_start_after_accept, in_fire, cmd.start)
    `FCD_ASSERT_IMP(a_slot_tick, cmd.slot, stat.is_tick)

endmodule
